@@ rtl/disk_dma_request_dispatcher_core_assert.svh @@
// Assertion macros shared by the dispatcher RTL.
`ifndef DISK_DMA_REQUEST_DISPATCHER_CORE_ASSERT_SVH
`define DISK_DMA_REQUEST_DISPATCHER_CORE_ASSERT_SVH

// Condition holds at every edge out of reset (expects clk and rst_n in scope).
`define DDRD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ddrd: invariant violated");

// Same-cycle implication.
`define DDRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddrd: implication violated");

// Next-cycle implication.
`define DDRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddrd: next-cycle implication violated");

`endif

@@ rtl/ddrd_pkg.sv @@
// Types and constants of the disk DMA request dispatcher.
package ddrd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_D2M    = 3'd0;
  localparam logic [2:0] KIND_M2D    = 3'd1;
  localparam logic [2:0] KIND_INQ    = 3'd2;
  localparam logic [2:0] KIND_MSENSE = 3'd3;
  localparam logic [2:0] KIND_ACK    = 3'd4;
  localparam logic [2:0] KIND_NAK    = 3'd5;

  // Units
  localparam logic [1:0] UNIT_FA  = 2'd0;
  localparam logic [1:0] UNIT_FB  = 2'd1;
  localparam logic [1:0] UNIT_HDD = 2'd2;

  // Hard-disk opcodes and target
  localparam logic [4:0] OP_READ   = 5'h08;
  localparam logic [4:0] OP_WRITE  = 5'h0a;
  localparam logic [4:0] OP_INQ    = 5'h12;
  localparam logic [4:0] OP_MSENSE = 5'h1a;
  localparam logic [2:0] TARGET_HDD = 3'd0;

  // drive_status bits
  localparam int STAT_FD_BUSY = 0;
  localparam int STAT_SIDE_N  = 1;
  localparam int STAT_HD_BUSY = 4;

  // Active-low drive select patterns (status bits 3:2)
  localparam logic [1:0] DSEL_A = 2'b10;
  localparam logic [1:0] DSEL_B = 2'b01;

  // FDC command top bits for read/write sector
  localparam logic [1:0] FCMD_RW = 2'b10;

  // Register indexes
  localparam logic [2:0] REG_FA_PRESENT = 3'd0;
  localparam logic [2:0] REG_FA_SIDES   = 3'd1;
  localparam logic [2:0] REG_FA_SPT     = 3'd2;
  localparam logic [2:0] REG_FB_PRESENT = 3'd3;
  localparam logic [2:0] REG_FB_SIDES   = 3'd4;
  localparam logic [2:0] REG_FB_SPT     = 3'd5;
  localparam logic [2:0] REG_HDD_PRES   = 3'd6;
  localparam logic [2:0] REG_HDD_BLOCKS = 3'd7;

  typedef enum logic [1:0] {
    FL_NONE = 2'd0,
    FL_NAK  = 2'd1,
    FL_XFER = 2'd2
  } fl_mode_t;

  typedef struct packed {
    logic        fa_present;
    logic [7:0]  fa_sides;
    logic [7:0]  fa_spt;
    logic        fb_present;
    logic [7:0]  fb_sides;
    logic [7:0]  fb_spt;
    logic        hdd_present;
    logic [23:0] hdd_blocks;
  } cfg_t;

  // Register values after reset: one-sided drives, nothing attached
  localparam cfg_t CFG_RESET = '{
    fa_present:  1'b0,
    fa_sides:    8'd1,
    fa_spt:      8'd0,
    fb_present:  1'b0,
    fb_sides:    8'd1,
    fb_spt:      8'd0,
    hdd_present: 1'b0,
    hdd_blocks:  24'd0
  };

  typedef struct packed {
    logic [23:0] dma_addr;
    logic [7:0]  sector_count;
    logic [7:0]  fdc_command;
    logic [7:0]  fd_track;
    logic [7:0]  fd_sector;
    logic [7:0]  drive_status;
    logic [7:0]  acsi_command;
    logic [7:0]  acsi_lba_high;
    logic [7:0]  acsi_lba_mid;
    logic [7:0]  acsi_lba_low;
    logic [7:0]  acsi_length;
  } in_item_t;

  // Classified request, handed from front to back
  typedef struct packed {
    logic [23:0] addr;
    logic        hd_busy;
    logic        hd_op_v;
    logic [2:0]  hd_kind;
    logic [23:0] hd_blk;
    logic [8:0]  hd_cnt;
    logic [7:0]  hd_words;
    logic [23:0] hd_param;
    fl_mode_t    fl_mode;
    logic [1:0]  fl_unit;
    logic [2:0]  fl_kind;
    logic [23:0] fl_blk;
    logic [7:0]  fl_cnt;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  unit;
    logic [23:0] first_block;
    logic [8:0]  block_count;
    logic [23:0] mem_address;
    logic [7:0]  reply_words;
    logic [23:0] reply_param;
    logic        last;
  } res_t;

endpackage

@@ rtl/ddrd_front.sv @@
// Front end: decodes a status snapshot and computes the floppy block in two stages.
module ddrd_front import ddrd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item_i,
  input  logic     push_i,
  output logic     full_o,
  input  cfg_t     cfg_i,
  input  logic     fifo_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  typedef struct packed {
    cmd_t        cmd;
    logic [16:0] trk_mul;  // side + track*sides
    logic [7:0]  spt;
    logic [7:0]  sector;
  } stage1_t;

  logic    s1_v_r, s1_v_nxt;
  logic    s2_v_r, s2_v_nxt;
  stage1_t s1_r, s1_nxt;
  cmd_t    s2_r, s2_nxt;
  logic    adv;

  logic [4:0]  op;
  logic [8:0]  len9;
  logic        hd_ok;
  logic [1:0]  dsel;
  logic        present;
  logic [7:0]  sides;
  logic [15:0] trk_sides;
  logic [23:0] prod;

  assign adv        = !s2_v_r || !fifo_full_i;
  assign full_o     = !adv;
  assign cmd_push_o = s2_v_r && !fifo_full_i;
  assign cmd_o      = s2_r;

  assign op    = item_i.acsi_command[4:0];
  assign len9  = (item_i.acsi_length == 8'd0) ? 9'd256 : {1'b0, item_i.acsi_length};
  assign hd_ok = (item_i.acsi_command[7:5] == TARGET_HDD) && cfg_i.hdd_present;
  assign dsel  = item_i.drive_status[3:2];

  always_comb begin
    s1_nxt = '0;
    present = 1'b0;
    sides   = 8'd0;
    s1_nxt.cmd.addr    = item_i.dma_addr;
    s1_nxt.cmd.hd_busy = item_i.drive_status[STAT_HD_BUSY];
    s1_nxt.cmd.hd_kind = KIND_ACK;
    case (op)
      OP_READ: begin
        s1_nxt.cmd.hd_op_v = hd_ok;
        s1_nxt.cmd.hd_kind = KIND_D2M;
        s1_nxt.cmd.hd_blk  = {3'b000, item_i.acsi_lba_high[4:0], item_i.acsi_lba_mid,
                              item_i.acsi_lba_low};
        s1_nxt.cmd.hd_cnt  = len9;
      end
      OP_WRITE: begin
        s1_nxt.cmd.hd_op_v = hd_ok;
        s1_nxt.cmd.hd_kind = KIND_M2D;
        s1_nxt.cmd.hd_blk  = {3'b000, item_i.acsi_lba_high[4:0], item_i.acsi_lba_mid,
                              item_i.acsi_lba_low};
        s1_nxt.cmd.hd_cnt  = len9;
      end
      OP_INQ: begin
        s1_nxt.cmd.hd_op_v  = hd_ok;
        s1_nxt.cmd.hd_kind  = KIND_INQ;
        s1_nxt.cmd.hd_words = len9[8:1];
        // additional length byte wraps mod 256
        s1_nxt.cmd.hd_param = {16'd0, item_i.acsi_length - 8'd8};
      end
      OP_MSENSE: begin
        s1_nxt.cmd.hd_op_v  = hd_ok;
        s1_nxt.cmd.hd_kind  = KIND_MSENSE;
        s1_nxt.cmd.hd_words = len9[8:1];
        s1_nxt.cmd.hd_param = cfg_i.hdd_blocks;
      end
      default: s1_nxt.cmd.hd_op_v = 1'b0;
    endcase

    // Floppy: select A or B; both or neither selected means no drive
    case (dsel)
      DSEL_A: begin
        present = cfg_i.fa_present;
        sides   = cfg_i.fa_sides;
        s1_nxt.spt = cfg_i.fa_spt;
        s1_nxt.cmd.fl_unit = UNIT_FA;
      end
      DSEL_B: begin
        present = cfg_i.fb_present;
        sides   = cfg_i.fb_sides;
        s1_nxt.spt = cfg_i.fb_spt;
        s1_nxt.cmd.fl_unit = UNIT_FB;
      end
      default: s1_nxt.cmd.fl_unit = UNIT_FA;
    endcase

    if (!item_i.drive_status[STAT_FD_BUSY]) begin
      s1_nxt.cmd.fl_mode = FL_NONE;
    end else if (!present) begin
      s1_nxt.cmd.fl_mode = FL_NAK;
    end else if (item_i.fdc_command[7:6] == FCMD_RW) begin
      s1_nxt.cmd.fl_mode = FL_XFER;
    end else begin
      s1_nxt.cmd.fl_mode = FL_NONE;
    end
    s1_nxt.cmd.fl_kind = item_i.fdc_command[5] ? KIND_M2D : KIND_D2M;
    s1_nxt.cmd.fl_cnt  = item_i.sector_count;
    trk_sides      = 16'(item_i.fd_track) * 16'(sides);
    s1_nxt.trk_mul = 17'(trk_sides) + 17'(!item_i.drive_status[STAT_SIDE_N]);
    s1_nxt.sector  = item_i.fd_sector;
  end

  // Second multiply: block = trk_mul*spt + sector - 1, mod 2^24
  assign prod = 24'(s1_r.trk_mul) * 24'(s1_r.spt);

  always_comb begin
    s2_nxt = s1_r.cmd;
    s2_nxt.fl_blk = prod + 24'(s1_r.sector) - 24'd1;
  end

  assign s1_v_nxt = adv ? push_i : s1_v_r;
  assign s2_v_nxt = adv ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

endmodule

@@ rtl/ddrd_cmd_fifo.sv @@
// Short command queue between front and back.
`include "disk_dma_request_dispatcher_core_assert.svh"
module ddrd_cmd_fifo import ddrd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full_o,
  input  logic rd_en,
  output logic empty_o,
  output cmd_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = !wr_en ? wr_ptr_r :
                      (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = !rd_en ? rd_ptr_r :
                      (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `DDRD_ASSERT_IMP(a_no_write_when_full, wr_en, !full_o)
  `DDRD_ASSERT_IMP(a_no_read_when_empty, rd_en, !empty_o)
  `DDRD_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH))
  `DDRD_ASSERT_NEXT(a_write_leaves_entry, wr_en && !rd_en, !empty_o)

endmodule

@@ rtl/ddrd_back.sv @@
// Back end: expands a command into its results, one per unstalled cycle.
`include "disk_dma_request_dispatcher_core_assert.svh"
module ddrd_back import ddrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic head_v_i,
  input  cmd_t head_i,
  output logic head_pop_o,
  input  logic pop_i,
  output logic res_v_o,
  output res_t res_o
);

  // Result slots of one command, in emission order
  localparam int SLOT_HD_OP  = 0;
  localparam int SLOT_HD_ACK = 1;
  localparam int SLOT_FL_1ST = 2;
  localparam int SLOT_FL_ACK = 3;

  logic [3:0] slots, rem, pick;
  logic [3:0] done_r, done_nxt;
  logic       is_last, can_load, emit, out_take;
  logic       out_v_r, out_v_nxt;
  res_t       out_r, res_c;

  always_comb begin
    slots = '0;
    slots[SLOT_HD_OP]  = head_i.hd_busy && head_i.hd_op_v;
    slots[SLOT_HD_ACK] = head_i.hd_busy;
    slots[SLOT_FL_1ST] = (head_i.fl_mode != FL_NONE);
    slots[SLOT_FL_ACK] = (head_i.fl_mode == FL_XFER);
  end

  assign rem      = head_v_i ? (slots & ~done_r) : '0;
  assign pick     = rem & (~rem + 4'd1);
  assign is_last  = ((rem & ~pick) == '0);
  assign out_take = out_v_r && pop_i;
  assign can_load = !out_v_r || out_take;
  assign emit     = head_v_i && (rem != '0) && can_load;
  // a command with no results retires without a transaction
  assign head_pop_o = head_v_i && ((rem == '0) || (emit && is_last));

  always_comb begin
    res_c = '0;
    res_c.last = is_last;
    if (pick[SLOT_HD_OP]) begin
      res_c.kind        = head_i.hd_kind;
      res_c.unit        = UNIT_HDD;
      res_c.first_block = head_i.hd_blk;
      res_c.block_count = head_i.hd_cnt;
      res_c.mem_address = head_i.addr;
      res_c.reply_words = head_i.hd_words;
      res_c.reply_param = head_i.hd_param;
    end else if (pick[SLOT_HD_ACK]) begin
      res_c.kind = KIND_ACK;
      res_c.unit = UNIT_HDD;
    end else if (pick[SLOT_FL_1ST]) begin
      res_c.unit = head_i.fl_unit;
      if (head_i.fl_mode == FL_XFER) begin
        res_c.kind        = head_i.fl_kind;
        res_c.first_block = head_i.fl_blk;
        res_c.block_count = {1'b0, head_i.fl_cnt};
        res_c.mem_address = head_i.addr;
      end else begin
        res_c.kind = KIND_NAK;
      end
    end else begin
      res_c.kind = KIND_ACK;
      res_c.unit = head_i.fl_unit;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (head_pop_o) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r | pick;
    end
  end

  assign out_v_nxt = emit ? 1'b1 : (out_take ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      done_r  <= done_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res_c;
    end
  end

  assign res_v_o = out_v_r;
  assign res_o   = out_r;

  `DDRD_ASSERT_IMP(a_done_within_plan, head_v_i, (done_r & ~slots) == 4'd0)
  `DDRD_ASSERT_IMP(a_done_clear_when_idle, !head_v_i, done_r == 4'd0)
  `DDRD_ASSERT_IMP(a_one_slot_per_emit, emit, $onehot(pick))
  `DDRD_ASSERT_NEXT(a_pop_clears_progress, head_pop_o, done_r == 4'd0)

endmodule

@@ rtl/disk_dma_request_dispatcher_core.sv @@
// Path: a snapshot passes both front stages, the command queue and the output register.
// Throughput: one snapshot accepted per cycle into the two-stage front end while full is low;
//   the back end emits one result per cycle when its output is free, up to 4 per snapshot.
// The command queue (CMD_DEPTH entries) and the output register set how far the sides decouple.
// Reset (rst_n low, synchronous): queues and pipeline emptied, registers to reset values.
// Top level of the disk DMA request dispatcher.
module disk_dma_request_dispatcher_core import ddrd_pkg::*; #(
  parameter int CMD_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Snapshot channel
  input  logic        push,
  output logic        full,
  input  logic [23:0] in_dma_addr,
  input  logic [7:0]  in_sector_count,
  input  logic [7:0]  in_fdc_command,
  input  logic [7:0]  in_fd_track,
  input  logic [7:0]  in_fd_sector,
  input  logic [7:0]  in_drive_status,
  input  logic [7:0]  in_acsi_command,
  input  logic [7:0]  in_acsi_lba_high,
  input  logic [7:0]  in_acsi_lba_mid,
  input  logic [7:0]  in_acsi_lba_low,
  input  logic [7:0]  in_acsi_length,
  // Result channel
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_unit,
  output logic [23:0] out_first_block,
  output logic [8:0]  out_block_count,
  output logic [23:0] out_mem_address,
  output logic [7:0]  out_reply_words,
  output logic [23:0] out_reply_param,
  output logic        out_last,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register file; to be written only while the datapath is idle, which only the user ensures
  cfg_t       cfg_r, cfg_nxt;
  logic       reg_wr;
  logic [2:0] reg_idx;

  in_item_t   item;
  cmd_t       fe_cmd, q_head;
  logic       fe_push, q_full, q_empty, q_pop;
  logic       res_v;
  res_t       res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];  // 32-bit registers at 4-byte stride
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_idx)
        REG_FA_PRESENT: cfg_nxt.fa_present  = pwdata[0];
        REG_FA_SIDES:   cfg_nxt.fa_sides    = pwdata[7:0];
        REG_FA_SPT:     cfg_nxt.fa_spt      = pwdata[7:0];
        REG_FB_PRESENT: cfg_nxt.fb_present  = pwdata[0];
        REG_FB_SIDES:   cfg_nxt.fb_sides    = pwdata[7:0];
        REG_FB_SPT:     cfg_nxt.fb_spt      = pwdata[7:0];
        REG_HDD_PRES:   cfg_nxt.hdd_present = pwdata[0];
        REG_HDD_BLOCKS: cfg_nxt.hdd_blocks  = pwdata[23:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FA_PRESENT: prdata = {31'd0, cfg_r.fa_present};
      REG_FA_SIDES:   prdata = {24'd0, cfg_r.fa_sides};
      REG_FA_SPT:     prdata = {24'd0, cfg_r.fa_spt};
      REG_FB_PRESENT: prdata = {31'd0, cfg_r.fb_present};
      REG_FB_SIDES:   prdata = {24'd0, cfg_r.fb_sides};
      REG_FB_SPT:     prdata = {24'd0, cfg_r.fb_spt};
      REG_HDD_PRES:   prdata = {31'd0, cfg_r.hdd_present};
      REG_HDD_BLOCKS: prdata = {8'd0, cfg_r.hdd_blocks};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;  // one-sided until told otherwise
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign item.dma_addr      = in_dma_addr;
  assign item.sector_count  = in_sector_count;
  assign item.fdc_command   = in_fdc_command;
  assign item.fd_track      = in_fd_track;
  assign item.fd_sector     = in_fd_sector;
  assign item.drive_status  = in_drive_status;
  assign item.acsi_command  = in_acsi_command;
  assign item.acsi_lba_high = in_acsi_lba_high;
  assign item.acsi_lba_mid  = in_acsi_lba_mid;
  assign item.acsi_lba_low  = in_acsi_lba_low;
  assign item.acsi_length   = in_acsi_length;

  // Front: decode + floppy block arithmetic (two multiplies, one per stage)
  ddrd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_i      (item),
    .push_i      (push),
    .full_o      (full),
    .cfg_i       (cfg_r),
    .fifo_full_i (q_full),
    .cmd_push_o  (fe_push),
    .cmd_o       (fe_cmd)
  );

  // Decoupling queue between classification and result emission
  ddrd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_push),
    .wr_data (fe_cmd),
    .full_o  (q_full),
    .rd_en   (q_pop),
    .empty_o (q_empty),
    .rd_data (q_head)
  );

  // Back: one result transaction per cycle into the output register while it is free
  ddrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_v_i   (!q_empty),
    .head_i     (q_head),
    .head_pop_o (q_pop),
    .pop_i      (pop),
    .res_v_o    (res_v),
    .res_o      (res)
  );

  assign empty           = !res_v;
  assign out_kind        = res.kind;
  assign out_unit        = res.unit;
  assign out_first_block = res.first_block;
  assign out_block_count = res.block_count;
  assign out_mem_address = res.mem_address;
  assign out_reply_words = res.reply_words;
  assign out_reply_param = res.reply_param;
  assign out_last        = res.last;

endmodule

@@ tb/sv/tb_disk_dma_request_dispatcher_core.sv @@
// Self-checking testbench for the disk DMA request dispatcher core.
`timescale 1ns / 1ps

module tb_disk_dma_request_dispatcher_core;
  import ddrd_pkg::*;

  // Bench constants
  localparam int          CLK_HALF     = 4;
  localparam int          RESET_CYCLES = 8;
  localparam int          DRAIN_TAIL   = 16;      // covers pipeline + command queue
  localparam int unsigned CYCLE_LIMIT  = 400000;  // slowest legal run is far below this
  localparam int          PHASES       = 5;
  localparam int          PHASE_ITEMS  = 48;

  // Codes the package does not name
  localparam logic [4:0] OP_UNKNOWN    = 5'h1f;
  localparam logic [2:0] TARGET_OTHER  = 3'd7;
  localparam logic [1:0] DSEL_NONE_HI  = 2'b11;
  localparam logic [1:0] DSEL_NONE_LO  = 2'b00;
  localparam logic [7:0] FDC_READ      = 8'h80;
  localparam logic [7:0] FDC_READ_MULT = 8'h9f;
  localparam logic [7:0] FDC_WRITE     = 8'ha0;
  localparam logic [7:0] FDC_FORCE_INT = 8'hd0;
  localparam logic [7:0] FDC_STEP_IN   = 8'h40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Snapshot side
  logic        push = 1'b0;
  logic        full;
  logic [23:0] in_dma_addr = '0;
  logic [7:0]  in_sector_count = '0;
  logic [7:0]  in_fdc_command = '0;
  logic [7:0]  in_fd_track = '0;
  logic [7:0]  in_fd_sector = '0;
  logic [7:0]  in_drive_status = '0;
  logic [7:0]  in_acsi_command = '0;
  logic [7:0]  in_acsi_lba_high = '0;
  logic [7:0]  in_acsi_lba_mid = '0;
  logic [7:0]  in_acsi_lba_low = '0;
  logic [7:0]  in_acsi_length = '0;

  // Result side
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_kind;
  logic [1:0]  out_unit;
  logic [23:0] out_first_block;
  logic [8:0]  out_block_count;
  logic [23:0] out_mem_address;
  logic [7:0]  out_reply_words;
  logic [23:0] out_reply_param;
  logic        out_last;

  // Register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench state
  cfg_t        shadow_cfg;            // what the registers hold right now
  res_t        pending_results[$];    // expected descriptors/handshakes, oldest first
  int          errors = 0;
  int unsigned cycle_count = 0;
  int          src_gap_pct = 0;       // chance of an input gap before a transaction
  int          sink_stall_pct = 0;    // chance of a pop stall burst starting
  int          sink_hold = 0;

  always #CLK_HALF clk = ~clk;

  disk_dma_request_dispatcher_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_dma_addr      (in_dma_addr),
    .in_sector_count  (in_sector_count),
    .in_fdc_command   (in_fdc_command),
    .in_fd_track      (in_fd_track),
    .in_fd_sector     (in_fd_sector),
    .in_drive_status  (in_drive_status),
    .in_acsi_command  (in_acsi_command),
    .in_acsi_lba_high (in_acsi_lba_high),
    .in_acsi_lba_mid  (in_acsi_lba_mid),
    .in_acsi_lba_low  (in_acsi_lba_low),
    .in_acsi_length   (in_acsi_length),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_unit         (out_unit),
    .out_first_block  (out_first_block),
    .out_block_count  (out_block_count),
    .out_mem_address  (out_mem_address),
    .out_reply_words  (out_reply_words),
    .out_reply_param  (out_reply_param),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Dispatch predictor: turns one accepted snapshot into the descriptors and
  // handshakes the core must emit, appended to pending_results in order.
  // ---------------------------------------------------------------------------
  function automatic void predict_dispatch(input in_item_t s);
    res_t        batch[4];
    int          n;
    res_t        r;
    logic [8:0]  len;
    logic [4:0]  op;
    logic [1:0]  dsel;
    logic        side;
    logic        present;
    logic [1:0]  unit;
    logic [7:0]  sides;
    logic [7:0]  spt;
    logic [31:0] blk;
    n = 0;
    // Length byte of 0 stands for 256 blocks / bytes
    len = (s.acsi_length == 8'd0) ? 9'd256 : {1'b0, s.acsi_length};

    // Hard-disk path goes first and always ends in an ack
    if (s.drive_status[STAT_HD_BUSY]) begin
      op = s.acsi_command[4:0];
      if (s.acsi_command[7:5] == TARGET_HDD && shadow_cfg.hdd_present) begin
        r = '0;
        r.unit = UNIT_HDD;
        r.mem_address = s.dma_addr;
        case (op)
          OP_READ, OP_WRITE: begin
            r.kind = (op == OP_READ) ? KIND_D2M : KIND_M2D;
            r.first_block = {3'b000, s.acsi_lba_high[4:0], s.acsi_lba_mid, s.acsi_lba_low};
            r.block_count = len;
            batch[n] = r;
            n++;
          end
          OP_INQ, OP_MSENSE: begin
            r.kind = (op == OP_INQ) ? KIND_INQ : KIND_MSENSE;
            r.reply_words = len[8:1];
            // Inquiry: additional length byte wraps modulo 256
            r.reply_param = (op == OP_INQ) ? {16'h0000, len[7:0] - 8'd8}
                                           : shadow_cfg.hdd_blocks;
            batch[n] = r;
            n++;
          end
          default: ;  // unknown opcode: ack only
        endcase
      end
      r = '0;
      r.kind = KIND_ACK;
      r.unit = UNIT_HDD;
      batch[n] = r;
      n++;
    end

    // Floppy path: active-low drive select and side
    if (s.drive_status[STAT_FD_BUSY]) begin
      dsel = s.drive_status[3:2];
      side = ~s.drive_status[STAT_SIDE_N];
      present = 1'b0;
      unit = UNIT_FA;
      sides = '0;
      spt = '0;
      if (dsel == DSEL_A) begin
        present = shadow_cfg.fa_present;
        unit = UNIT_FA;
        sides = shadow_cfg.fa_sides;
        spt = shadow_cfg.fa_spt;
      end else if (dsel == DSEL_B) begin
        present = shadow_cfg.fb_present;
        unit = UNIT_FB;
        sides = shadow_cfg.fb_sides;
        spt = shadow_cfg.fb_spt;
      end
      r = '0;
      if (!present) begin
        // No drive selected or no image: nak on the selected unit (A if none)
        r.kind = KIND_NAK;
        r.unit = unit;
        batch[n] = r;
        n++;
      end else if (s.fdc_command[7:6] == FCMD_RW) begin
        // Sector 0 wraps through the subtraction, kept modulo 2^24
        blk = ({31'd0, side} + {24'd0, s.fd_track} * {24'd0, sides}) * {24'd0, spt}
              + {24'd0, s.fd_sector} - 32'd1;
        r.kind = s.fdc_command[5] ? KIND_M2D : KIND_D2M;
        r.unit = unit;
        r.first_block = blk[23:0];
        r.block_count = {1'b0, s.sector_count};
        r.mem_address = s.dma_addr;
        batch[n] = r;
        n++;
        r = '0;
        r.kind = KIND_ACK;
        r.unit = unit;
        batch[n] = r;
        n++;
      end
    end

    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Drives one snapshot and returns in the time step of its acceptance edge.
  // push is left high so back-to-back snapshots need no extra assignment.
  task automatic send_snapshot(input in_item_t s);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push             <= 1'b1;
    in_dma_addr      <= s.dma_addr;
    in_sector_count  <= s.sector_count;
    in_fdc_command   <= s.fdc_command;
    in_fd_track      <= s.fd_track;
    in_fd_sector     <= s.fd_sector;
    in_drive_status  <= s.drive_status;
    in_acsi_command  <= s.acsi_command;
    in_acsi_lba_high <= s.acsi_lba_high;
    in_acsi_lba_mid  <= s.acsi_lba_mid;
    in_acsi_lba_low  <= s.acsi_lba_low;
    in_acsi_length   <= s.acsi_length;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_dispatch(s);
  endtask

  // Stops input and waits until every predicted result has been popped, then
  // lets snapshots that produce nothing clear the pipeline.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Writes all eight registers back to back (setup + access each); only
  // called with the core idle.
  task automatic program_regs(input cfg_t c);
    logic [2:0]  idx;
    logic [31:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = i[2:0];
      case (idx)
        REG_FA_PRESENT: val = {31'd0, c.fa_present};
        REG_FA_SIDES:   val = {24'd0, c.fa_sides};
        REG_FA_SPT:     val = {24'd0, c.fa_spt};
        REG_FB_PRESENT: val = {31'd0, c.fb_present};
        REG_FB_SIDES:   val = {24'd0, c.fb_sides};
        REG_FB_SPT:     val = {24'd0, c.fb_spt};
        REG_HDD_PRES:   val = {31'd0, c.hdd_present};
        default:        val = {8'd0, c.hdd_blocks};
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);  // register takes the value here (pready tied high)
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_cfg = c;
  endtask

  function automatic in_item_t hdd_snapshot(input logic [7:0] acmd, input logic [23:0] lba,
                                            input logic [7:0] len, input logic [23:0] addr);
    in_item_t s;
    s = '0;
    s.drive_status[STAT_HD_BUSY] = 1'b1;
    s.acsi_command  = acmd;
    s.acsi_lba_high = lba[23:16];
    s.acsi_lba_mid  = lba[15:8];
    s.acsi_lba_low  = lba[7:0];
    s.acsi_length   = len;
    s.dma_addr      = addr;
    return s;
  endfunction

  function automatic in_item_t floppy_snapshot(input logic [1:0] dsel, input logic side_n,
                                               input logic [7:0] cmd, input logic [7:0] track,
                                               input logic [7:0] sector,
                                               input logic [7:0] count);
    in_item_t s;
    s = '0;
    s.drive_status[STAT_FD_BUSY] = 1'b1;
    s.drive_status[3:2] = dsel;
    s.drive_status[STAT_SIDE_N] = side_n;
    s.fdc_command  = cmd;
    s.fd_track     = track;
    s.fd_sector    = sector;
    s.sector_count = count;
    s.dma_addr     = 24'($urandom);
    return s;
  endfunction

  // Mostly well-formed requests with random content; the rest raw noise
  function automatic in_item_t random_snapshot();
    in_item_t    s;
    int unsigned mode;
    logic [4:0]  op;
    s.dma_addr      = 24'($urandom);
    s.sector_count  = 8'($urandom);
    s.fdc_command   = 8'($urandom);
    s.fd_track      = 8'($urandom);
    s.fd_sector     = 8'($urandom);
    s.drive_status  = 8'($urandom);
    s.acsi_command  = 8'($urandom);
    s.acsi_lba_high = 8'($urandom);
    s.acsi_lba_mid  = 8'($urandom);
    s.acsi_lba_low  = 8'($urandom);
    s.acsi_length   = 8'($urandom);
    mode = $urandom_range(0, 99);
    if (mode < 85) begin
      // 0..39 hard disk only, 40..54 both paths, 55..84 floppy only
      s.drive_status[STAT_HD_BUSY] = (mode < 55);
      s.drive_status[STAT_FD_BUSY] = (mode >= 40);
      if (s.drive_status[STAT_HD_BUSY] && $urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 3))
          0:       op = OP_READ;
          1:       op = OP_WRITE;
          2:       op = OP_INQ;
          default: op = OP_MSENSE;
        endcase
        s.acsi_command = {TARGET_HDD, op};
      end
      if (s.drive_status[STAT_FD_BUSY]) begin
        if ($urandom_range(0, 4) != 0)
          s.drive_status[3:2] = $urandom_range(0, 1) ? DSEL_A : DSEL_B;
        if ($urandom_range(0, 3) != 0) s.fdc_command[7:6] = FCMD_RW;
      end
    end
    return s;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.fa_present  = ($urandom_range(0, 3) != 0);
    c.fa_sides    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    c.fa_spt      = 8'($urandom);
    c.fb_present  = ($urandom_range(0, 3) != 0);
    c.fb_sides    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    c.fb_spt      = 8'($urandom);
    c.hdd_present = ($urandom_range(0, 3) != 0);
    c.hdd_blocks  = 24'($urandom);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop stall bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      pop <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      sink_hold <= $urandom_range(0, 18);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every popped transaction is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d unit %0d",
                 $time, out_kind, out_unit);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind",        24'(want.kind),        24'(out_kind));
        check_field("unit",        24'(want.unit),        24'(out_unit));
        check_field("first_block", want.first_block,      out_first_block);
        check_field("block_count", 24'(want.block_count), 24'(out_block_count));
        check_field("mem_address", want.mem_address,      out_mem_address);
        check_field("reply_words", 24'(want.reply_words), 24'(out_reply_words));
        check_field("reply_param", want.reply_param,      out_reply_param);
        check_field("last",        24'(want.last),        24'(out_last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset: no drives, no disk
  task automatic test_unconfigured();
    in_item_t s;
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_READ}, 24'h000123, 8'd4, 24'h001000));
    send_snapshot(floppy_snapshot(DSEL_A, 1'b1, FDC_READ, 8'd0, 8'd1, 8'd1));
    send_snapshot(floppy_snapshot(DSEL_B, 1'b0, FDC_WRITE, 8'd3, 8'd2, 8'd1));
    // Neither path busy, everything else at its maximum: nothing comes out
    s = '1;
    s.drive_status[STAT_HD_BUSY] = 1'b0;
    s.drive_status[STAT_FD_BUSY] = 1'b0;
    send_snapshot(s);
  endtask

  task automatic test_hdd_commands();
    cfg_t c;
    drain_results();
    c = shadow_cfg;
    c.hdd_present = 1'b1;
    c.hdd_blocks = 24'hffffff;
    program_regs(c);
    // Widest block address (upper bits of the high byte ignored), length 0 = 256
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_READ}, 24'hffffff, 8'd0, 24'hffffff));
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_WRITE}, 24'h000000, 8'd1, 24'h000000));
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_INQ}, 24'h000000, 8'd0, 24'h0a5a5a));
    // Short inquiry: additional length wraps below zero
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_INQ}, 24'h000000, 8'd7, 24'h000100));
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_MSENSE}, 24'h000000, 8'd255, 24'h123456));
    send_snapshot(hdd_snapshot({TARGET_HDD, OP_UNKNOWN}, 24'h00ffff, 8'd8, 24'h000200));
    send_snapshot(hdd_snapshot({TARGET_OTHER, OP_READ}, 24'h000010, 8'd2, 24'h000300));
  endtask

  task automatic test_floppy_commands();
    cfg_t     c;
    in_item_t s;
    drain_results();
    c = shadow_cfg;
    c.fa_present = 1'b1;
    c.fa_sides = 8'd2;
    c.fa_spt = 8'd9;
    c.fb_present = 1'b1;
    c.fb_sides = 8'd255;
    c.fb_spt = 8'd255;
    program_regs(c);
    send_snapshot(floppy_snapshot(DSEL_A, 1'b1, FDC_READ, 8'd0, 8'd1, 8'd1));
    send_snapshot(floppy_snapshot(DSEL_A, 1'b0, FDC_WRITE, 8'd79, 8'd9, 8'd9));
    // Largest geometry and register values on drive B
    send_snapshot(floppy_snapshot(DSEL_B, 1'b0, FDC_READ_MULT, 8'd255, 8'd255, 8'd255));
    // Sector 0 wraps the block number; sector count 0 gives an empty transfer
    send_snapshot(floppy_snapshot(DSEL_A, 1'b1, FDC_READ, 8'd0, 8'd0, 8'd0));
    // Non read/write commands produce nothing
    send_snapshot(floppy_snapshot(DSEL_A, 1'b1, FDC_FORCE_INT, 8'd5, 8'd1, 8'd1));
    send_snapshot(floppy_snapshot(DSEL_B, 1'b1, FDC_STEP_IN, 8'd5, 8'd1, 8'd1));
    // Both select lines inactive or both active: no drive
    send_snapshot(floppy_snapshot(DSEL_NONE_HI, 1'b1, FDC_READ, 8'd1, 8'd1, 8'd1));
    send_snapshot(floppy_snapshot(DSEL_NONE_LO, 1'b0, FDC_WRITE, 8'd1, 8'd1, 8'd1));
    // Both paths busy: disk results first, four in all
    s = hdd_snapshot({TARGET_HDD, OP_READ}, 24'h012345, 8'd16, 24'h040000);
    s.drive_status[STAT_FD_BUSY] = 1'b1;
    s.drive_status[3:2] = DSEL_A;
    s.fdc_command = FDC_WRITE;
    s.fd_track = 8'd40;
    s.fd_sector = 8'd3;
    s.sector_count = 8'd2;
    send_snapshot(s);
    // Drive B image removed: nak on unit B
    drain_results();
    c = shadow_cfg;
    c.fb_present = 1'b0;
    program_regs(c);
    send_snapshot(floppy_snapshot(DSEL_B, 1'b1, FDC_READ, 8'd2, 8'd4, 8'd1));
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin  // everything at its maximum
          c.fa_present = 1'b1;  c.fa_sides = 8'hff;  c.fa_spt = 8'hff;
          c.fb_present = 1'b1;  c.fb_sides = 8'hff;  c.fb_spt = 8'hff;
          c.hdd_present = 1'b1; c.hdd_blocks = 24'hffffff;
        end
        1: begin  // ordinary double-sided images
          c.fa_present = 1'b1;  c.fa_sides = 8'd2;   c.fa_spt = 8'd9;
          c.fb_present = 1'b1;  c.fb_sides = 8'd2;   c.fb_spt = 8'd18;
          c.hdd_present = 1'b1; c.hdd_blocks = 24'd40960;
        end
        3: begin  // zero geometry
          c.fa_present = 1'b1;  c.fa_sides = 8'd0;   c.fa_spt = 8'd0;
          c.fb_present = 1'b1;  c.fb_sides = 8'd0;   c.fb_spt = 8'd0;
          c.hdd_present = 1'b1; c.hdd_blocks = 24'd0;
        end
        default: c = random_config();
      endcase
      program_regs(c);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == PHASES - 1) begin
          // closing stretch runs flat out on both sides
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end else if (i % 13 == 0) begin
          // re-roll idling; on each side roughly a third of the stretches have none
          src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
          sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        end
        // Mid-phase pause: sender holds off until the core has drained
        if (p == 2 && i == PHASE_ITEMS / 2) drain_results();
        send_snapshot(random_snapshot());
      end
    end
  endtask

  initial begin
    shadow_cfg = '0;
    shadow_cfg.fa_sides = 8'd1;
    shadow_cfg.fb_sides = 8'd1;
    src_gap_pct = 20;
    sink_stall_pct = 20;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unconfigured();
    test_hdd_commands();
    test_floppy_commands();
    test_random_traffic();
    drain_results();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
